FILE: rtl/fta_pkg.sv
// Shared types and constants of the frame timing accumulator.
package fta_pkg;

    localparam int FREQ_W  = 40;
    localparam int SCALE_W = 24;
    localparam int STEP_W  = 24;
    localparam int TICK_W  = 64;
    localparam int UDT_W   = 23;
    localparam int SDT_W   = 30;
    localparam int TOT_W   = 56;
    localparam int ACC_W   = 31;
    localparam int SCNT_W  = 4;
    localparam int ALPHA_W = 17;
    localparam int CIDX_W  = 2;

    localparam int DIV_QW  = 22;
    localparam int DIV_RW  = 40;
    localparam int DIV_CW  = 5;

    localparam logic [DIV_CW-1:0] FT_ITERS = 5'd22;
    localparam logic [DIV_CW-1:0] AL_ITERS = 5'd17;

    localparam logic [UDT_W-1:0]   FRAME_CLAMP = 23'd4194304;
    localparam logic [FREQ_W-1:0]  FREQ_RST    = 40'd10000000;
    localparam logic [SCALE_W-1:0] SCALE_RST   = 24'd65536;
    localparam logic [STEP_W-1:0]  STEP_RST    = 24'd279620;

    localparam logic [CIDX_W-1:0] REG_FREQ  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_SCALE = 2'd1;
    localparam logic [CIDX_W-1:0] REG_STEP  = 2'd2;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic restart;
        logic first;
        logic clamp_ft;
        logic div_ft_start;
        logic div_ft_store;
        logic mul;
        logic acc;
        logic step_sub;
        logic acc_clamp;
        logic div_al_start;
        logic div_al_store;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic req;
        logic started;
        logic ft_over;
        logic div_done;
        logic step_more;
    } t_sts;

endpackage

FILE: rtl/fta_div.sv
// Restoring divider, one quotient bit per cycle.
module fta_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fta_pkg::DIV_RW-1:0]  i_rem,
    input  logic [fta_pkg::DIV_QW-1:0]  i_bits,
    input  logic [fta_pkg::DIV_RW-1:0]  i_divisor,
    input  logic [fta_pkg::DIV_CW-1:0]  i_iters,
    output logic                        o_done,
    output logic [fta_pkg::DIV_QW-1:0]  o_quot
);
    import fta_pkg::*;

    logic [DIV_RW-1:0] r_rem;
    logic [DIV_QW-1:0] r_bits;
    logic [DIV_RW-1:0] r_div;
    logic [DIV_QW-1:0] r_quot;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_RW:0] n_trial;
    logic [DIV_RW:0] n_diff;
    logic            n_ge;

    assign n_trial = {r_rem, r_bits[DIV_QW-1]};
    assign n_diff  = n_trial - {1'b0, r_div};
    assign n_ge    = n_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CW'(1);
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_rem;
            r_bits <= i_bits;
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_ge ? n_diff[DIV_RW-1:0] : n_trial[DIV_RW-1:0];
            r_bits <= {r_bits[DIV_QW-2:0], 1'b0};
            r_quot <= {r_quot[DIV_QW-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: rtl/fta_dp.sv
// Datapath: config registers, timing state, multiplier, step loop and output register.
module fta_dp #(
    parameter int MAX_STEPS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fta_pkg::t_cmd                 i_cmd,
    output fta_pkg::t_sts                 o_sts,
    input  logic                          i_cfg_we,
    input  logic [fta_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [fta_pkg::FREQ_W-1:0]    i_cfg_data,
    input  logic                          i_req_type,
    input  logic [fta_pkg::TICK_W-1:0]    i_now_ticks,
    output logic [fta_pkg::UDT_W-1:0]     o_unscaled_dt,
    output logic [fta_pkg::SDT_W-1:0]     o_game_dt,
    output logic [fta_pkg::TOT_W-1:0]     o_game_total,
    output logic [fta_pkg::TOT_W-1:0]     o_real_total,
    output logic [fta_pkg::SCNT_W-1:0]    o_step_count,
    output logic [fta_pkg::ALPHA_W-1:0]   o_alpha
);
    import fta_pkg::*;

    localparam int CW = $clog2(MAX_STEPS + 1);
    localparam int SW = (CW > SCNT_W) ? CW : SCNT_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_STEPS);

    logic [FREQ_W-1:0]  r_freq;
    logic [SCALE_W-1:0] r_scale;
    logic [STEP_W-1:0]  r_step;

    logic               r_req;
    logic [TICK_W-1:0]  r_now;
    logic [TICK_W-1:0]  r_last;
    logic               r_started;
    logic [TOT_W-1:0]   r_real;
    logic [TOT_W-1:0]   r_game;
    logic [ACC_W-1:0]   r_acc;

    logic [UDT_W-1:0]   r_udt;
    logic [SDT_W-1:0]   r_sdt;
    logic [CW-1:0]      r_cnt;
    logic [ALPHA_W-1:0] r_alpha;

    logic [TICK_W-1:0]   n_diff;
    logic [TICK_W+1:0]   n_diff4;
    logic [46:0]         n_prod;
    logic [ACC_W-1:0]    n_step;
    logic [SW-1:0]       n_cnt_ext;

    logic                div_start;
    logic [DIV_RW-1:0]   div_rem;
    logic [DIV_QW-1:0]   div_bits;
    logic [DIV_RW-1:0]   div_divisor;
    logic [DIV_CW-1:0]   div_iters;
    logic                div_done;
    logic [DIV_QW-1:0]   div_quot;

    assign n_diff  = r_now - r_last;
    assign n_diff4 = {n_diff, 2'b00};
    assign n_prod  = 47'(r_udt) * 47'(r_scale);
    assign n_step  = ACC_W'(r_step);
    assign n_cnt_ext = SW'(r_cnt);

    always_comb begin
        div_start   = i_cmd.div_ft_start || i_cmd.div_al_start;
        div_rem     = {n_diff[DIV_RW-3:0], 2'b00};
        div_bits    = '0;
        div_divisor = r_freq;
        div_iters   = FT_ITERS;
        if (i_cmd.div_al_start) begin
            div_rem     = DIV_RW'(r_acc[ACC_W-1:1]);
            div_bits    = {r_acc[0], {(DIV_QW-1){1'b0}}};
            div_divisor = DIV_RW'(r_step);
            div_iters   = AL_ITERS;
        end
    end

    fta_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_rem     (div_rem),
        .i_bits    (div_bits),
        .i_divisor (div_divisor),
        .i_iters   (div_iters),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    always_comb begin
        o_sts.req       = r_req;
        o_sts.started   = r_started;
        o_sts.ft_over   = n_diff4 >= (TICK_W+2)'(r_freq);
        o_sts.div_done  = div_done;
        o_sts.step_more = (r_acc >= n_step) && (r_cnt < MAX_CNT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq  <= FREQ_RST;
            r_scale <= SCALE_RST;
            r_step  <= STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FREQ: begin
                    if (i_cfg_data != '0) r_freq <= i_cfg_data;
                end
                REG_SCALE: begin
                    r_scale <= i_cfg_data[SCALE_W-1:0];
                end
                REG_STEP: begin
                    if (i_cfg_data[STEP_W-1:0] != '0) r_step <= i_cfg_data[STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= '0;
            r_started <= 1'b0;
            r_real    <= '0;
            r_game    <= '0;
            r_acc     <= '0;
        end else begin
            if (i_cmd.prep) r_last <= r_now;
            if (i_cmd.restart) begin
                r_started <= 1'b0;
                r_real    <= '0;
                r_game    <= '0;
                r_acc     <= '0;
            end
            if (i_cmd.first) r_started <= 1'b1;
            if (i_cmd.acc) begin
                r_real <= r_real + TOT_W'(r_udt);
                r_game <= r_game + TOT_W'(r_sdt);
                r_acc  <= r_acc + ACC_W'(r_sdt);
            end
            if (i_cmd.step_sub) r_acc <= r_acc - n_step;
            if (i_cmd.acc_clamp && (r_acc > n_step)) r_acc <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req <= i_req_type;
            r_now <= i_now_ticks;
        end
        if (i_cmd.restart || i_cmd.first) begin
            r_udt   <= '0;
            r_sdt   <= '0;
            r_cnt   <= '0;
            r_alpha <= '0;
        end
        if (i_cmd.clamp_ft) r_udt <= FRAME_CLAMP;
        if (i_cmd.div_ft_store) r_udt <= UDT_W'(div_quot);
        if (i_cmd.mul) r_sdt <= n_prod[SDT_W+15:16];
        if (i_cmd.acc) r_cnt <= '0;
        if (i_cmd.step_sub) r_cnt <= r_cnt + CW'(1);
        if (i_cmd.div_al_store) r_alpha <= div_quot[ALPHA_W-1:0];
        if (i_cmd.out_load) begin
            o_unscaled_dt <= r_udt;
            o_game_dt     <= r_sdt;
            o_game_total  <= r_game;
            o_real_total  <= r_real;
            o_step_count  <= n_cnt_ext[SCNT_W-1:0];
            o_alpha       <= r_alpha;
        end
    end

endmodule

FILE: rtl/fta_ctrl.sv
// Controller state machine sequencing one item through the datapath.
module fta_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  fta_pkg::t_sts i_sts,
    output fta_pkg::t_cmd o_cmd
);
    import fta_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_FTDIV = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_ACC   = 4'd4;
    localparam logic [3:0] S_STEP  = 4'd5;
    localparam logic [3:0] S_ALST  = 4'd6;
    localparam logic [3:0] S_ALDIV = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_ovalid;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_sts.req) begin
                    o_cmd.restart = 1'b1;
                    n_state       = S_DONE;
                end else if (!i_sts.started) begin
                    o_cmd.first = 1'b1;
                    n_state     = S_DONE;
                end else if (i_sts.ft_over) begin
                    o_cmd.clamp_ft = 1'b1;
                    n_state        = S_MUL;
                end else begin
                    o_cmd.div_ft_start = 1'b1;
                    n_state            = S_FTDIV;
                end
            end
            S_FTDIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_ft_store = 1'b1;
                    n_state            = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_STEP;
            end
            S_STEP: begin
                if (i_sts.step_more) begin
                    o_cmd.step_sub = 1'b1;
                end else begin
                    o_cmd.acc_clamp = 1'b1;
                    n_state         = S_ALST;
                end
            end
            S_ALST: begin
                o_cmd.div_al_start = 1'b1;
                n_state            = S_ALDIV;
            end
            S_ALDIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_al_store = 1'b1;
                    n_state            = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/fixed_timestep_accumulator.sv
// Top level of the fixed timestep frame timing accumulator.
// One item at a time: a frame item holds the input from its accept to the earliest next accept,
// the longer the more fixed steps it takes (at most MAX_STEPS); a clamped frame time skips the
// frame time divide. Restart and first-frame items go straight from preparation to the output
// register. The time per frame item is set by the shared restoring divider, which yields one
// quotient bit per cycle (22 for the frame time, 17 for alpha), and by the step loop, which
// subtracts one fixed step per cycle and ends with an exit test. The finished result waits
// in an output register while the next item is accepted; a result still waiting there holds
// back the next one. Config writes are always ready and take effect at once; write them only
// while the block is idle.
module fixed_timestep_accumulator #(
    parameter int MAX_STEPS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_req_type,
    input  logic [fta_pkg::TICK_W-1:0]    i_now_ticks,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [fta_pkg::UDT_W-1:0]     o_unscaled_dt,
    output logic [fta_pkg::SDT_W-1:0]     o_game_dt,
    output logic [fta_pkg::TOT_W-1:0]     o_game_total,
    output logic [fta_pkg::TOT_W-1:0]     o_real_total,
    output logic [fta_pkg::SCNT_W-1:0]    o_step_count,
    output logic [fta_pkg::ALPHA_W-1:0]   o_alpha,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fta_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [fta_pkg::FREQ_W-1:0]    i_cfg_data
);
    import fta_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    fta_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    fta_dp #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (i_req_type),
        .i_now_ticks    (i_now_ticks),
        .o_unscaled_dt  (o_unscaled_dt),
        .o_game_dt      (o_game_dt),
        .o_game_total   (o_game_total),
        .o_real_total   (o_real_total),
        .o_step_count   (o_step_count),
        .o_alpha        (o_alpha)
    );

endmodule
